// ----- hw/rtl/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check prop on every clock edge outside reset
`define RBI_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// check prop on every clock edge, reset included
`define RBI_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ----- hw/rtl/rbi_pkg.sv -----
`timescale 1ns / 1ps

package rbi_pkg;

    localparam int COORD_W = 32;
    localparam int DIR_W   = 18;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int NUM_W   = COORD_W + 2;
    localparam int DEN_W   = DIR_W + 1;
    localparam int PROD_W  = NUM_W + DEN_W;
    localparam int AXES    = 3;

    localparam int IN_W    = 2 * AXES * COORD_W;
    localparam int OUT_W   = 8;
    localparam int CFG_A_W = 3;
    localparam int CFG_D_W = COORD_W;

    localparam logic signed [DIR_W-1:0] DIR_X_RESET = DIR_W'(65536);

    typedef enum logic [CFG_A_W-1:0] {
        REG_ORIGIN_X = 3'd0,
        REG_ORIGIN_Y = 3'd1,
        REG_ORIGIN_Z = 3'd2,
        REG_DIR_X    = 3'd3,
        REG_DIR_Y    = 3'd4,
        REG_DIR_Z    = 3'd5
    } reg_idx_t;

    typedef struct packed {
        logic                      outside;
        logic                      valid;
        logic signed [NUM_W-1:0]   num;
        logic signed [DEN_W-1:0]   den;
        logic signed [DIFF_W-1:0]  dlo;
        logic signed [DIFF_W-1:0]  dhi;
    } axis_t;

endpackage

// ----- hw/rtl/rbi_axis_prep.sv -----
`timescale 1ns / 1ps

module rbi_axis_prep (
    input  logic signed [rbi_pkg::COORD_W-1:0] origin,
    input  logic signed [rbi_pkg::DIR_W-1:0]   dir,
    input  logic signed [rbi_pkg::COORD_W-1:0] lo,
    input  logic signed [rbi_pkg::COORD_W-1:0] hi,
    output rbi_pkg::axis_t                     ax
);

    logic                                below;
    logic                                above;
    logic signed [rbi_pkg::COORD_W-1:0]  plane;
    logic signed [rbi_pkg::DIFF_W-1:0]   num_raw;
    logic                                flip;

    always_comb begin
        below   = origin < lo;
        above   = origin > hi;
        plane   = below ? lo : hi;
        num_raw = rbi_pkg::DIFF_W'(plane) - rbi_pkg::DIFF_W'(origin);
        flip    = dir < 0;
        ax.outside = below | above;
        ax.valid   = (below | above) && (dir != '0);
        ax.num     = flip ? -rbi_pkg::NUM_W'(num_raw) : rbi_pkg::NUM_W'(num_raw);
        ax.den     = flip ? -rbi_pkg::DEN_W'(dir) : rbi_pkg::DEN_W'(dir);
        ax.dlo     = rbi_pkg::DIFF_W'(lo) - rbi_pkg::DIFF_W'(origin);
        ax.dhi     = rbi_pkg::DIFF_W'(hi) - rbi_pkg::DIFF_W'(origin);
    end

endmodule

// ----- hw/rtl/ray_box_intersection_unit.sv -----
`timescale 1ns / 1ps
// An accepted request passes stages s1 to s4 and the result register.
// Throughput: one box per cycle; all five stages advance together and
// hold while the result register waits on m_tready.
// Reset (aresetn low, synchronous): pipeline emptied, origin 0,
// direction (1, 0, 0).
`include "assert_macros.svh"

module ray_box_intersection_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [rbi_pkg::CFG_A_W-1:0]   cfg_index,
    input  logic [rbi_pkg::CFG_D_W-1:0]   cfg_data,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z
    input  logic [rbi_pkg::IN_W-1:0]      s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // hit, zero padded
    output logic [rbi_pkg::OUT_W-1:0]     m_tdata
);

    localparam int A = rbi_pkg::AXES;

    logic signed [rbi_pkg::COORD_W-1:0] origin_reg [A];
    logic signed [rbi_pkg::DIR_W-1:0]   dir_reg    [A];

    logic adv;

    rbi_pkg::axis_t ax_next [A];

    logic           s1_valid_reg;
    rbi_pkg::axis_t s1_ax_reg [A];

    logic                              s2_valid_reg;
    rbi_pkg::axis_t                    s2_ax_reg [A];
    logic signed [rbi_pkg::PROD_W-1:0] p01_reg, p10_reg, p02_reg, p20_reg, p12_reg, p21_reg;

    logic                              s3_valid_reg;
    logic                              s3_inside_reg;
    logic                              s3_has_reg;
    logic [1:0]                        s3_best_reg;
    logic [A-1:0]                      s3_axvalid_reg;
    logic signed [rbi_pkg::NUM_W-1:0]  s3_num_reg;
    logic signed [rbi_pkg::DEN_W-1:0]  s3_den_reg;
    logic signed [rbi_pkg::DIFF_W-1:0] s3_dlo_reg [A];
    logic signed [rbi_pkg::DIFF_W-1:0] s3_dhi_reg [A];

    logic                              s4_valid_reg;
    logic                              s4_inside_reg;
    logic                              s4_has_reg;
    logic                              s4_neg_reg;
    logic [1:0]                        s4_best_reg;
    logic signed [rbi_pkg::PROD_W-1:0] s4_tr_reg [A];
    logic signed [rbi_pkg::PROD_W-1:0] s4_lo_reg [A];
    logic signed [rbi_pkg::PROD_W-1:0] s4_hi_reg [A];

    logic m_tvalid_reg;
    logic hit_reg;

    logic       inside_next;
    logic       has_next;
    logic [1:0] best_next;
    logic       hit_next;
    logic [A-1:0] ok;

    assign adv      = !m_tvalid_reg || m_tready;
    assign s_tready = adv;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = rbi_pkg::OUT_W'(hit_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            origin_reg[0] <= '0;
            origin_reg[1] <= '0;
            origin_reg[2] <= '0;
            dir_reg[0]    <= rbi_pkg::DIR_X_RESET;
            dir_reg[1]    <= '0;
            dir_reg[2]    <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                rbi_pkg::REG_ORIGIN_X: origin_reg[0] <= cfg_data;
                rbi_pkg::REG_ORIGIN_Y: origin_reg[1] <= cfg_data;
                rbi_pkg::REG_ORIGIN_Z: origin_reg[2] <= cfg_data;
                rbi_pkg::REG_DIR_X:    dir_reg[0] <= cfg_data[rbi_pkg::DIR_W-1:0];
                rbi_pkg::REG_DIR_Y:    dir_reg[1] <= cfg_data[rbi_pkg::DIR_W-1:0];
                rbi_pkg::REG_DIR_Z:    dir_reg[2] <= cfg_data[rbi_pkg::DIR_W-1:0];
                default: ;
            endcase
        end
    end

    for (genvar g = 0; g < A; g++) begin : g_prep
        rbi_axis_prep u_prep (
            .origin (origin_reg[g]),
            .dir    (dir_reg[g]),
            .lo     (s_tdata[rbi_pkg::COORD_W*g +: rbi_pkg::COORD_W]),
            .hi     (s_tdata[rbi_pkg::COORD_W*(g+A) +: rbi_pkg::COORD_W]),
            .ax     (ax_next[g])
        );
    end

    always_comb begin
        inside_next = !(s2_ax_reg[0].outside || s2_ax_reg[1].outside
                        || s2_ax_reg[2].outside);
        has_next  = 1'b0;
        best_next = 2'd0;
        if (s2_ax_reg[0].valid) begin
            has_next  = 1'b1;
            best_next = 2'd0;
        end
        if (s2_ax_reg[1].valid && (!has_next || p10_reg > p01_reg)) begin
            has_next  = 1'b1;
            best_next = 2'd1;
        end
        if (s2_ax_reg[2].valid && (!has_next
                || (best_next == 2'd0 && p20_reg > p02_reg)
                || (best_next == 2'd1 && p21_reg > p12_reg))) begin
            has_next  = 1'b1;
            best_next = 2'd2;
        end
    end

    always_comb begin
        for (int i = 0; i < A; i++) begin
            ok[i] = (s4_best_reg == 2'(i))
                    || (s4_tr_reg[i] >= s4_lo_reg[i] && s4_tr_reg[i] <= s4_hi_reg[i]);
        end
        hit_next = s4_inside_reg || (s4_has_reg && !s4_neg_reg && (&ok));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else if (adv) begin
            s1_valid_reg <= s_tvalid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            m_tvalid_reg <= s4_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < A; i++) begin
                s1_ax_reg[i] <= ax_next[i];
                s2_ax_reg[i] <= s1_ax_reg[i];
                s3_dlo_reg[i] <= s2_ax_reg[i].dlo;
                s3_dhi_reg[i] <= s2_ax_reg[i].dhi;
                s3_axvalid_reg[i] <= s2_ax_reg[i].valid;
                s4_tr_reg[i] <= rbi_pkg::PROD_W'(s3_num_reg)
                                * rbi_pkg::PROD_W'(dir_reg[i]);
                s4_lo_reg[i] <= rbi_pkg::PROD_W'(s3_dlo_reg[i])
                                * rbi_pkg::PROD_W'(s3_den_reg);
                s4_hi_reg[i] <= rbi_pkg::PROD_W'(s3_dhi_reg[i])
                                * rbi_pkg::PROD_W'(s3_den_reg);
            end
            p01_reg <= rbi_pkg::PROD_W'(s1_ax_reg[0].num) * rbi_pkg::PROD_W'(s1_ax_reg[1].den);
            p10_reg <= rbi_pkg::PROD_W'(s1_ax_reg[1].num) * rbi_pkg::PROD_W'(s1_ax_reg[0].den);
            p02_reg <= rbi_pkg::PROD_W'(s1_ax_reg[0].num) * rbi_pkg::PROD_W'(s1_ax_reg[2].den);
            p20_reg <= rbi_pkg::PROD_W'(s1_ax_reg[2].num) * rbi_pkg::PROD_W'(s1_ax_reg[0].den);
            p12_reg <= rbi_pkg::PROD_W'(s1_ax_reg[1].num) * rbi_pkg::PROD_W'(s1_ax_reg[2].den);
            p21_reg <= rbi_pkg::PROD_W'(s1_ax_reg[2].num) * rbi_pkg::PROD_W'(s1_ax_reg[1].den);

            s3_inside_reg <= inside_next;
            s3_has_reg    <= has_next;
            s3_best_reg   <= best_next;
            s3_num_reg    <= s2_ax_reg[best_next].num;
            s3_den_reg    <= s2_ax_reg[best_next].den;

            s4_inside_reg <= s3_inside_reg;
            s4_has_reg    <= s3_has_reg;
            s4_neg_reg    <= s3_num_reg < 0;
            s4_best_reg   <= s3_best_reg;

            hit_reg <= hit_next;
        end
    end

    `RBI_ASSERT(a_best_is_candidate,
        s3_valid_reg && s3_has_reg |-> (s3_best_reg == 2'd0 && s3_axvalid_reg[0])
        || (s3_best_reg == 2'd1 && s3_axvalid_reg[1])
        || (s3_best_reg == 2'd2 && s3_axvalid_reg[2]),
        "chosen axis has no candidate plane")
    `RBI_ASSERT(a_stall_holds_s4,
        !adv |=> $stable(s4_valid_reg) && $stable(s4_best_reg),
        "stage 4 moved during stall")
    `RBI_ASSERT(a_flow, adv && s4_valid_reg |=> m_tvalid_reg,
        "stage 4 item lost on advance")
    `RBI_ASSERT_ALWAYS(a_reset_empty, !aresetn |=> !m_tvalid_reg && !s1_valid_reg,
        "pipeline not empty after reset")

endmodule
